@@ src/mtt_pkg.sv @@
// ----------------------------------------------------------------------------
// mtt_pkg: shared constants for the marble turbulence texture core
// Field widths, register indexes, item kind codes and the fixed-point
// constants of the sine evaluation.
// ----------------------------------------------------------------------------
package mtt_pkg;

	// field and store widths
	localparam int STORE_AW = 15;
	localparam int NOISE_W  = 16;
	localparam int COORD_W  = 24;
	localparam int CFG_W    = 4;
	localparam int CFG_AW   = 2;

	// configuration register indexes
	localparam logic [CFG_AW-1:0] CFG_X_PERIOD   = 2'd0;
	localparam logic [CFG_AW-1:0] CFG_Y_PERIOD   = 2'd1;
	localparam logic [CFG_AW-1:0] CFG_TURB_POWER = 2'd2;

	// item kind carried in tuser
	localparam logic KIND_SAMPLE = 1'b1;

	// pi and one in Q30
	localparam logic [31:0] PI_Q30  = 32'd3373259426;
	localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

	// horner steps of the sine series, divisors and their 2^32 reciprocals
	localparam int HSTEPS = 5;
	localparam logic [7:0] HDIV [HSTEPS] = '{8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
	localparam logic [29:0] HRECIP [HSTEPS] = '{
		30'(64'h1_0000_0000 / 64'd110),
		30'(64'h1_0000_0000 / 64'd72),
		30'(64'h1_0000_0000 / 64'd42),
		30'(64'h1_0000_0000 / 64'd20),
		30'(64'h1_0000_0000 / 64'd6)
	};

endpackage

@@ src/mtt_ram.sv @@
// ----------------------------------------------------------------------------
// mtt_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module mtt_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32768
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ src/marble_turbulence_texture_core.sv @@
// ----------------------------------------------------------------------------
// marble_turbulence_texture_core: procedural marble texture pipeline
// Value-noise turbulence over a loadable 3-D lattice, turned into a
// periodic grey level |sin(pi*phase)|.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel takes requests. tuser = 1 samples the point in tdata, tuser = 0
//   writes one noise entry into the lattice and gives no result.
//   m_* channel returns one intensity per sample request, in request order.
//   cfg_we/cfg_addr/cfg_wdata write x_period, y_period and turb_power; write
//   them only while no sample is in flight.
// Issue: a sample holds the issue stage while its octaves go out (one octave
//   of eight lattice reads per cycle from eight lattice copies, while the output
//   does not stall) and blocks new requests meanwhile; a noise write does not.
// Reset: clears the pipeline valid bits and loads the register defaults; the
//   lattice holds nothing until written and needs no clearing pass.
// Stall: while m_tvalid is high and m_tready is low the whole pipeline and
//   the lattice read ports hold, and s_tready drops.
// ----------------------------------------------------------------------------
module marble_turbulence_texture_core
	import mtt_pkg::*;
#(
	parameter int LATTICE_WIDTH  = 32,
	parameter int LATTICE_HEIGHT = 32,
	parameter int LATTICE_DEPTH  = 32,
	parameter int OCTAVES        = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	// [14:0] noise_address, [30:15] noise_value, [54:31] coord_x,
	// [78:55] coord_y, [102:79] coord_z, [103] zero
	input  logic [103:0]       s_tdata,
	// [0] kind
	input  logic               s_tuser,
	output logic               m_tvalid,
	input  logic               m_tready,
	// [15:0] intensity
	output logic [15:0]        m_tdata,
	input  logic               cfg_we,
	input  logic [CFG_AW-1:0]  cfg_addr,
	input  logic [CFG_W-1:0]   cfg_wdata
);

	localparam int KW = (OCTAVES > 1) ? $clog2(OCTAVES) : 1;
	localparam int DIM [3] = '{LATTICE_WIDTH, LATTICE_HEIGHT, LATTICE_DEPTH};
	// offsets that make lattice indexes non-negative, multiples of the size
	localparam int VOFF_K [3] = '{(32768 + LATTICE_WIDTH - 1) / LATTICE_WIDTH,
		(32768 + LATTICE_HEIGHT - 1) / LATTICE_HEIGHT,
		(32768 + LATTICE_DEPTH - 1) / LATTICE_DEPTH};
	localparam int VREC [3] = '{(1 << 18) / LATTICE_WIDTH,
		(1 << 18) / LATTICE_HEIGHT, (1 << 18) / LATTICE_DEPTH};
	// coordinate term dividers, x over width and y over height
	localparam int AK [2] = '{((1 << 27) + LATTICE_WIDTH - 1) / LATTICE_WIDTH,
		((1 << 27) + LATTICE_HEIGHT - 1) / LATTICE_HEIGHT};
	localparam int AREC [2] = '{(1 << 29) / LATTICE_WIDTH, (1 << 29) / LATTICE_HEIGHT};
	localparam int RREC [2] = '{(1 << 24) / LATTICE_WIDTH, (1 << 24) / LATTICE_HEIGHT};
	localparam int SUM_W = 56;

	typedef struct packed {
		logic          vld;
		logic          load;
		logic          first;
		logic          last;
		logic [KW-1:0] k;
	} ctl_t;

	logic en;

	// configuration registers
	logic [CFG_W-1:0] xp_q, yp_q, tp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xp_q <= 4'd1;
			yp_q <= 4'd0;
			tp_q <= 4'd5;
		end else if (cfg_we) begin
			case (cfg_addr)
				CFG_X_PERIOD:   xp_q <= cfg_wdata;
				CFG_Y_PERIOD:   yp_q <= cfg_wdata;
				CFG_TURB_POWER: tp_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// output register parts the pipeline from the receiver
	logic        out_vld_q;
	logic [15:0] out_dat_q;

	assign en       = !out_vld_q || m_tready;
	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_dat_q;

	// issue stage: holds a sample while its octaves go out
	logic                s0_vld_q, s0_load_q;
	logic [KW-1:0]       s0_k_q;
	logic [COORD_W-1:0]  crd_q [3];
	logic [STORE_AW-1:0] nad_q;
	logic [NOISE_W-1:0]  nval_q;
	logic                hold;

	assign hold     = s0_vld_q && !s0_load_q && (s0_k_q != '0);
	assign s_tready = en && !hold;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s0_vld_q  <= 1'b0;
			s0_load_q <= 1'b0;
			s0_k_q    <= '0;
		end else if (en) begin
			if (hold) begin
				s0_k_q <= s0_k_q - 1'b1;
			end else begin
				s0_vld_q  <= s_tvalid;
				s0_load_q <= (s_tuser != KIND_SAMPLE);
				s0_k_q    <= KW'(OCTAVES - 1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			nad_q    <= s_tdata[14:0];
			nval_q   <= s_tdata[30:15];
			crd_q[0] <= s_tdata[54:31];
			crd_q[1] <= s_tdata[78:55];
			crd_q[2] <= s_tdata[102:79];
		end
	end

	// control travels with the data
	ctl_t ctl_s [1:10];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 1; j <= 10; j++) ctl_s[j] <= '0;
		end else if (en) begin
			ctl_s[1].vld   <= s0_vld_q;
			ctl_s[1].load  <= s0_load_q;
			ctl_s[1].first <= (s0_k_q == KW'(OCTAVES - 1));
			ctl_s[1].last  <= (s0_k_q == '0);
			ctl_s[1].k     <= s0_k_q;
			for (int j = 2; j <= 10; j++) ctl_s[j] <= ctl_s[j-1];
		end
	end

	// stage 1: octave shift, lattice index offset, coordinate products
	logic signed [COORD_W-1:0] sh [3];
	logic signed [28:0]        ax [2];
	logic [16:0]               v_s1 [3];
	logic [7:0]                fr_s1 [3];
	logic [28:0]               va_s1 [2];
	logic [STORE_AW-1:0]       nad_s1;
	logic [NOISE_W-1:0]        nval_s1;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sh[i] = $signed(crd_q[i]) >>> s0_k_q;
		end
		ax[0] = $signed(crd_q[0]) * $signed({1'b0, xp_q});
		ax[1] = $signed(crd_q[1]) * $signed({1'b0, yp_q});
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				v_s1[i]  <= 17'({{2{sh[i][23]}}, sh[i][23:8]} + 18'(VOFF_K[i] * DIM[i]));
				fr_s1[i] <= sh[i][7:0];
			end
			for (int i = 0; i < 2; i++) begin
				va_s1[i] <= 29'(ax[i] + 29'(AK[i] * DIM[i]));
			end
			nad_s1  <= nad_q;
			nval_s1 <= nval_q;
		end
	end

	// stage 2: reciprocal products for the constant divisions
	logic [34:0]         pv_s2 [3];
	logic [16:0]         v_s2 [3];
	logic [7:0]          fr_s2 [3];
	logic [57:0]         pa_s2 [2];
	logic [28:0]         va_s2 [2];
	logic [STORE_AW-1:0] nad_s2;
	logic [NOISE_W-1:0]  nval_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				pv_s2[i] <= 35'(v_s1[i]) * 35'(VREC[i]);
				v_s2[i]  <= v_s1[i];
				fr_s2[i] <= fr_s1[i];
			end
			for (int i = 0; i < 2; i++) begin
				pa_s2[i] <= 58'(va_s1[i]) * 58'(AREC[i]);
				va_s2[i] <= va_s1[i];
			end
			nad_s2  <= nad_s1;
			nval_s2 <= nval_s1;
		end
	end

	// stage 3: quotient correction, wrapped lattice indexes
	logic [24:0]         re_v [3];
	logic [7:0]          hi_c [3];
	logic [37:0]         re_a [2];
	logic [28:0]         qa_c [2];
	logic [7:0]          ra_c [2];
	logic [7:0]          hi_s3 [3];
	logic [7:0]          lo_s3 [3];
	logic [7:0]          fr_s3 [3];
	logic [7:0]          ra_s3 [2];
	logic [7:0]          qa_s3 [2];
	logic [STORE_AW-1:0] nad_s3;
	logic [NOISE_W-1:0]  nval_s3;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			re_v[i] = 25'(v_s2[i]) - 25'(pv_s2[i][34:18]) * 25'(DIM[i]);
			hi_c[i] = (re_v[i] >= 25'(DIM[i])) ? 8'(re_v[i] - 25'(DIM[i])) : 8'(re_v[i]);
		end
		for (int i = 0; i < 2; i++) begin
			re_a[i] = 38'(va_s2[i]) - 38'(pa_s2[i][57:29]) * 38'(DIM[i]);
			if (re_a[i] >= 38'(DIM[i])) begin
				qa_c[i] = pa_s2[i][57:29] + 1'b1;
				ra_c[i] = 8'(re_a[i] - 38'(DIM[i]));
			end else begin
				qa_c[i] = pa_s2[i][57:29];
				ra_c[i] = 8'(re_a[i]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				hi_s3[i] <= hi_c[i];
				lo_s3[i] <= (hi_c[i] == 8'd0) ? 8'(DIM[i] - 1) : hi_c[i] - 8'd1;
				fr_s3[i] <= fr_s2[i];
			end
			for (int i = 0; i < 2; i++) begin
				ra_s3[i] <= ra_c[i];
				qa_s3[i] <= qa_c[i][7:0] - 8'(AK[i]);
			end
			nad_s3  <= nad_s2;
			nval_s3 <= nval_s2;
		end
	end

	// stage 4: corner addresses, weight pairs, remainder products
	logic [8:0]          wgt [3][2];
	logic [7:0]          cx, cy, cz;
	logic [STORE_AW-1:0] addr_s4 [8];
	logic [17:0]         wxy_s4 [4];
	logic [8:0]          wz_s4 [2];
	logic [47:0]         pr_s4 [2];
	logic [7:0]          ra_s4 [2];
	logic [7:0]          qa_s4 [2];
	logic [STORE_AW-1:0] nad_s4;
	logic [NOISE_W-1:0]  nval_s4;
	logic [STORE_AW-1:0] addr_c [8];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			wgt[i][1] = {1'b0, fr_s3[i]};
			wgt[i][0] = 9'd256 - {1'b0, fr_s3[i]};
		end
		cx = '0;
		cy = '0;
		cz = '0;
		for (int c = 0; c < 8; c++) begin
			cx = c[0] ? hi_s3[0] : lo_s3[0];
			cy = c[1] ? hi_s3[1] : lo_s3[1];
			cz = c[2] ? hi_s3[2] : lo_s3[2];
			addr_c[c] = STORE_AW'((32'(cz) * 32'(DIM[1]) + 32'(cy)) * 32'(DIM[0])
				+ 32'(cx));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 8; c++) addr_s4[c] <= addr_c[c];
			for (int b = 0; b < 2; b++) begin
				for (int a = 0; a < 2; a++) begin
					wxy_s4[b*2+a] <= 18'(wgt[0][a]) * 18'(wgt[1][b]);
				end
				wz_s4[b] <= wgt[2][b];
			end
			for (int i = 0; i < 2; i++) begin
				pr_s4[i] <= 48'({ra_s3[i], 16'h0000}) * 48'(RREC[i]);
				ra_s4[i] <= ra_s3[i];
				qa_s4[i] <= qa_s3[i];
			end
			nad_s4  <= nad_s3;
			nval_s4 <= nval_s3;
		end
	end

	// lattice copies, one read port per cube corner, all written together
	logic [NOISE_W-1:0] rd_s5 [8];
	logic               lat_we;

	assign lat_we = en && ctl_s[4].vld && ctl_s[4].load;

	for (genvar c = 0; c < 8; c++) begin : g_lat
		mtt_ram #(
			.WIDTH(NOISE_W),
			.DEPTH(1 << STORE_AW)
		) u_lat (
			.clk  (clk),
			.we   (lat_we),
			.waddr(nad_s4),
			.wdata(nval_s4),
			.re   (en),
			.raddr(addr_s4[c]),
			.rdata(rd_s5[c])
		);
	end

	// stage 5: full corner weights, coordinate term quotients
	logic [31:0] rr [2];
	logic [23:0] qr [2];
	logic [26:0] w3_s5 [8];
	logic [23:0] txy_s5 [2];

	always_comb begin
		for (int i = 0; i < 2; i++) begin
			rr[i] = 32'({ra_s4[i], 16'h0000}) - 32'(pr_s4[i][47:24]) * 32'(DIM[i]);
			qr[i] = (rr[i] >= 32'(DIM[i])) ? pr_s4[i][47:24] + 1'b1 : pr_s4[i][47:24];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 8; c++) begin
				w3_s5[c] <= 27'(wxy_s4[c[1:0]]) * 27'(wz_s4[c[2]]);
			end
			for (int i = 0; i < 2; i++) txy_s5[i] <= {qa_s4[i], qr[i][15:0]};
		end
	end

	// stages 6 to 9: weighted samples and adder tree
	logic [42:0] pd_s6 [8];
	logic [43:0] sa_s7 [4];
	logic [44:0] sb_s8 [2];
	logic [45:0] acc_s9;
	logic [23:0] tsum_s [6:11];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 8; c++) pd_s6[c] <= 43'(w3_s5[c]) * 43'(rd_s5[c]);
			for (int j = 0; j < 4; j++) sa_s7[j] <= 44'(pd_s6[2*j]) + 44'(pd_s6[2*j+1]);
			for (int j = 0; j < 2; j++) sb_s8[j] <= 45'(sa_s7[2*j]) + 45'(sa_s7[2*j+1]);
			acc_s9 <= 46'(sb_s8[0]) + 46'(sb_s8[1]);
			tsum_s[6] <= txy_s5[0] + txy_s5[1];
			for (int j = 7; j <= 11; j++) tsum_s[j] <= tsum_s[j-1];
		end
	end

	// stage 10: octave accumulation
	logic [SUM_W-1:0] sum_s10;
	logic [SUM_W-1:0] acc_sh;

	assign acc_sh = SUM_W'(acc_s9) << ctl_s[9].k;

	always_ff @(posedge clk) begin
		if (en && ctl_s[9].vld && !ctl_s[9].load) begin
			sum_s10 <= ctl_s[9].first ? acc_sh : sum_s10 + acc_sh;
		end
	end

	// result valid pipe from the last octave onward
	logic rv_s [10:30];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 10; j <= 30; j++) rv_s[j] <= 1'b0;
		end else if (en) begin
			rv_s[10] <= ctl_s[9].vld && !ctl_s[9].load && ctl_s[9].last;
			for (int j = 11; j <= 30; j++) rv_s[j] <= rv_s[j-1];
		end
	end

	// stages 11 to 14: phase, fold, theta and theta squared
	logic [SUM_W+3:0] tprod;
	logic [23:0]      turb_s11;
	logic [23:0]      ph;
	logic [23:0]      u_s12;
	logic [30:0]      th_s13, th_s14;
	logic [31:0]      t2_s14;

	assign tprod = (SUM_W + 4)'(tp_q) * (SUM_W + 4)'(sum_s10);
	assign ph    = turb_s11 + tsum_s[11];

	always_ff @(posedge clk) begin
		if (en) begin
			turb_s11 <= tprod[OCTAVES+16+23:OCTAVES+16];
			u_s12    <= (ph > 24'h80_0000) ? 24'(25'h100_0000 - 25'(ph)) : ph;
			th_s13   <= 31'((56'(u_s12) * 56'(PI_Q30)) >> 24);
			t2_s14   <= 32'((62'(th_s13) * 62'(th_s13)) >> 30);
			th_s14   <= th_s13;
		end
	end

	// stages 15 to 29: horner steps, multiply, reciprocal, correct
	logic [30:0] hd_th [15];
	logic [31:0] hd_t2 [15];
	logic [62:0] mp_s [HSTEPS];
	logic [31:0] hx_s [HSTEPS];
	logic [61:0] qm_s [HSTEPS];
	logic [30:0] tn_s [HSTEPS];
	logic [39:0] hr [HSTEPS];
	logic [30:0] hq [HSTEPS];

	always_comb begin
		for (int i = 0; i < HSTEPS; i++) begin
			hr[i] = 40'(hx_s[i]) - 40'(qm_s[i][61:32]) * 40'(HDIV[i]);
			hq[i] = (hr[i] >= 40'(HDIV[i])) ? 31'(qm_s[i][61:32]) + 31'd1
				: 31'(qm_s[i][61:32]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hd_th[0] <= th_s14;
			hd_t2[0] <= t2_s14;
			for (int j = 1; j < 15; j++) begin
				hd_th[j] <= hd_th[j-1];
				hd_t2[j] <= hd_t2[j-1];
			end
			mp_s[0] <= 63'(t2_s14) * 63'(ONE_Q30);
			for (int i = 1; i < HSTEPS; i++) begin
				mp_s[i] <= 63'(hd_t2[3*i-1]) * 63'(tn_s[i-1]);
			end
			for (int i = 0; i < HSTEPS; i++) begin
				hx_s[i] <= mp_s[i][61:30];
				qm_s[i] <= 62'(mp_s[i][61:30]) * 62'(HRECIP[i]);
				tn_s[i] <= ONE_Q30 - hq[i];
			end
		end
	end

	// stage 30: sine value, then rounding into the output register
	logic [30:0] sv_s30;
	logic [31:0] rnd;

	assign rnd = (32'(sv_s30) + 32'h2000) >> 14;

	always_ff @(posedge clk) begin
		if (en) begin
			sv_s30 <= 31'((62'(hd_th[14]) * 62'(tn_s[HSTEPS-1])) >> 30);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= rv_s[30];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_dat_q <= (rnd > 32'd65535) ? 16'hFFFF : rnd[15:0];
		end
	end

	// a sample with octaves left blocks new requests
	a_hold_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(s0_vld_q && !s0_load_q && s0_k_q != '0) |-> !s_tready)
		else $error("request taken while octaves remain");

	// wrapped lattice x index stays inside the lattice
	a_index_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl_s[3].vld && !ctl_s[3].load) |->
		(hi_s3[0] < 8'(DIM[0] - 1) || hi_s3[0] == 8'(DIM[0] - 1)))
		else $error("lattice x index out of range");

	// folded phase never passes one half
	a_fold: assert property (@(posedge clk) disable iff (!arst_n)
		rv_s[12] |-> (u_s12 <= 24'h80_0000))
		else $error("phase fold out of range");

	// last horner term stays at or below one
	a_horner: assert property (@(posedge clk) disable iff (!arst_n)
		rv_s[29] |-> (tn_s[HSTEPS-1] <= ONE_Q30))
		else $error("sine series term above one");

	// the output register only fills from a finished sample
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		(!$past(out_vld_q) && out_vld_q) |-> $past(rv_s[30]))
		else $error("result without a sample");

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: marble turbulence texture core regression
// Fills the block of noise lattice entries that the sample points touch,
// then sends directed and random sample and noise write requests under
// several register settings. A scoreboard predicts each intensity and
// checks the results in order. Random idle bursts fall on both sides, and
// there is one long output stall.
// ----------------------------------------------------------------------------
module testbench;
	import mtt_pkg::*;

	localparam int LAT_W   = 32;
	localparam int LAT_H   = 32;
	localparam int LAT_D   = 32;
	localparam int OCT_N   = 4;
	localparam int DRAIN   = 30 + OCT_N + 16;
	localparam logic KIND_NOISE = ~KIND_SAMPLE;
	localparam logic [CFG_AW-1:0] CFG_UNUSED = 2'd3;

	// scoreboard: own lattice and register copy, queue of predicted levels
	class marble_scoreboard;
		logic [15:0] lattice [32768];
		logic [3:0]  x_per, y_per, turb_pow;
		logic [15:0] expected_levels [$];
		int          mismatches;

		function new();
			x_per      = 4'd1;
			y_per      = 4'd0;
			turb_pow   = 4'd5;
			mismatches = 0;
		endfunction

		function void set_register(logic [CFG_AW-1:0] idx, logic [3:0] val);
			case (idx)
				CFG_X_PERIOD:   x_per = val;
				CFG_Y_PERIOD:   y_per = val;
				CFG_TURB_POWER: turb_pow = val;
				default: ;
			endcase
		endfunction

		function longint wrap_index(longint v, longint n);
			longint r;
			r = v % n;
			if (r < 0) r += n;
			return r;
		endfunction

		// trilinear blend of one octave, Q0.40
		function longint unsigned octave_blend(longint pt [3], int k);
			longint       dims [3];
			longint       hi [3], lo [3], s, ip, ix, iy, iz;
			longint unsigned w [3][2], acc, addr;
			dims = '{LAT_W, LAT_H, LAT_D};
			acc  = 0;
			for (int i = 0; i < 3; i++) begin
				s = pt[i] >>> k;
				ip = s >>> 8;
				w[i][1] = longint'(s & 255);
				w[i][0] = 256 - w[i][1];
				hi[i] = wrap_index(ip, dims[i]);
				lo[i] = wrap_index(ip - 1, dims[i]);
			end
			for (int c = 0; c < 2; c++)
				for (int b = 0; b < 2; b++)
					for (int a = 0; a < 2; a++) begin
						ix = a ? hi[0] : lo[0];
						iy = b ? hi[1] : lo[1];
						iz = c ? hi[2] : lo[2];
						addr = ((iz * LAT_H + iy) * LAT_W + ix) & 32767;
						acc += w[0][a] * w[1][b] * w[2][c] * lattice[addr];
					end
			return acc;
		endfunction

		// |sin(pi*u)| for a Q0.24 phase, Horner taylor series
		function logic [15:0] abs_sine(logic [23:0] ph);
			longint unsigned divs [5];
			longint unsigned u, th, t2, t, s, r, one;
			divs = '{110, 72, 42, 20, 6};
			one = 64'd1 << 30;
			u = ph;
			if (u > 64'h80_0000) u = 64'h100_0000 - u;
			th = (u * 64'd3373259426) >> 24;
			t2 = (th * th) >> 30;
			t = one;
			for (int i = 0; i < 5; i++)
				t = one - ((t2 * t) >> 30) / divs[i];
			s = (th * t) >> 30;
			r = (s + (64'd1 << 13)) >> 14;
			if (r > 65535) r = 65535;
			return r[15:0];
		endfunction

		function logic [15:0] predict_intensity(logic [23:0] cx, cy, cz);
			longint          pt [3];
			longint unsigned sum;
			longint          phase;
			pt = '{longint'($signed(cx)), longint'($signed(cy)), longint'($signed(cz))};
			sum = 0;
			for (int k = OCT_N - 1; k >= 0; k--)
				sum += octave_blend(pt, k) << k;
			phase = longint'((longint'(turb_pow) * sum) >> (OCT_N + 16));
			phase += (pt[0] * x_per * 65536) >>> $clog2(LAT_W);
			phase += (pt[1] * y_per * 65536) >>> $clog2(LAT_H);
			return abs_sine(phase[23:0]);
		endfunction

		function void note_request(logic kind, logic [103:0] data);
			if (kind == KIND_SAMPLE)
				expected_levels.push_back(predict_intensity(data[54:31], data[78:55],
					data[102:79]));
			else
				lattice[data[14:0]] = data[30:15];
		endfunction

		task report(string msg);
			$display("mismatch at %0t: %s", $realtime, msg);
			mismatches++;
		endtask

		task check_intensity(logic [15:0] got);
			logic [15:0] want;
			if (expected_levels.size() == 0) begin
				report($sformatf("unexpected intensity %h", got));
				return;
			end
			want = expected_levels.pop_front();
			if (got !== want)
				report($sformatf("intensity %h, expected %h", got, want));
		endtask
	endclass

	logic               clk;
	logic               arst_n;
	logic               s_tvalid;
	logic               s_tready;
	// [14:0] noise_address, [30:15] noise_value, [54:31] coord_x,
	// [78:55] coord_y, [102:79] coord_z, [103] zero
	logic [103:0]       s_tdata;
	// [0] kind
	logic               s_tuser;
	logic               m_tvalid;
	logic               m_tready;
	// [15:0] intensity
	logic [15:0]        m_tdata;
	logic               cfg_we;
	logic [CFG_AW-1:0]  cfg_addr;
	logic [CFG_W-1:0]   cfg_wdata;

	marble_scoreboard sb;
	bit               idle_on;
	bit               hold_now;

	marble_turbulence_texture_core u_dut (.*);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// watch both channels at the clock edge
	always @(posedge clk) begin
		if (s_tvalid && s_tready) sb.note_request(s_tuser, s_tdata);
		if (m_tvalid && m_tready) sb.check_intensity(m_tdata);
	end

	// receiver: random stall bursts plus one long hold-off on request
	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_now) begin
				m_tready <= 1'b0;
				repeat (300) @(posedge clk);
				hold_now = 1'b0;
			end else if (idle_on && $urandom_range(0, 3) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	task automatic send_request(logic kind, logic [14:0] addr, logic [15:0] val,
			logic [23:0] cx, logic [23:0] cy, logic [23:0] cz);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {1'b0, cz, cy, cx, val, addr};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic send_sample(logic [23:0] cx, logic [23:0] cy, logic [23:0] cz);
		send_request(KIND_SAMPLE, 15'($urandom), 16'($urandom), cx, cy, cz);
	endtask

	// points whose lattice indexes stay on 30, 31, 0 and 1 in every octave:
	// any multiple of 2^16 plus an offset from -256 to 511
	function automatic logic [23:0] pick_coord();
		logic [23:0] base;
		base = {8'($urandom), 16'h0000};
		case ($urandom_range(0, 3))
			0: return base + 24'($urandom_range(0, 511));
			1: return 24'($urandom_range(0, 511));
			2: return -24'($urandom_range(1, 256));
			default: return base - 24'($urandom_range(1, 256));
		endcase
	endfunction

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.expected_levels.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic write_register(logic [CFG_AW-1:0] idx, logic [3:0] val);
		cfg_we    <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= val;
		sb.set_register(idx, val);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic random_phase(int count);
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(0, 4) == 0)
				send_request(KIND_NOISE, 15'($urandom), 16'($urandom), 24'($urandom),
					24'($urandom), 24'($urandom));
			else
				send_sample(pick_coord(), pick_coord(), pick_coord());
		end
	endtask

	// limit on the whole run
	initial begin
		#5ms;
		$display("Regression FAIL");
		$finish;
	end

	// main sequence
	initial begin
		logic [3:0] cfg_sets [5][3];
		logic [4:0] fx, fy, fz;
		sb        = new();
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tuser   = 1'b0;
		s_tdata   = '0;
		cfg_we    = 1'b0;
		cfg_addr  = '0;
		cfg_wdata = '0;
		idle_on   = 1'b0;
		hold_now  = 1'b0;
		cfg_sets  = '{'{4'd0, 4'd0, 4'd0}, '{4'd15, 4'd15, 4'd15}, '{4'd3, 4'd7, 4'd1},
			'{4'($urandom), 4'($urandom), 4'($urandom)}, '{4'd2, 4'd0, 4'd15}};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fill the cube of indexes 30, 31, 0 and 1 on each axis, which is
		// every entry that the sample points below can reach
		for (int a = 0; a < 64; a++) begin
			fx = 5'(a % 4) + 5'd30;
			fy = 5'((a / 4) % 4) + 5'd30;
			fz = 5'(a / 16) + 5'd30;
			send_request(KIND_NOISE, {fz, fy, fx}, (a == 0) ? 16'h0000 : (a == 1) ? 16'hFFFF
				: 16'($urandom), 24'($urandom), 24'($urandom), 24'($urandom));
		end

		// directed samples under reset register values
		idle_on = 1'b1;
		send_sample(24'd0, 24'd0, 24'd0);
		send_sample(24'h7F_FFFF, 24'h7F_FFFF, 24'h7F_FFFF);
		send_sample(24'h80_0000, 24'h80_0000, 24'h80_0000);
		send_sample(24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF);
		send_sample(24'h00_00FF, 24'h00_0100, 24'hFF_FF00);
		send_sample(-24'd256, 24'd511, 24'h12_01FF);
		send_sample(24'd128, -24'd128, 24'd1);
		send_request(KIND_NOISE, 15'd0, 16'hFFFF, 24'd0, 24'd0, 24'd0);
		send_request(KIND_NOISE, 15'h7FFF, 16'h0000, 24'd0, 24'd0, 24'd0);
		send_sample(24'd0, 24'd0, 24'd0);
		send_sample(-24'd1, -24'd1, -24'd1);

		// first random part with a long output hold-off
		hold_now = 1'b1;
		random_phase(70);
		wait_drained();

		// further register settings, the last one without idling
		for (int p = 0; p < 5; p++) begin
			write_register(CFG_X_PERIOD, cfg_sets[p][0]);
			write_register(CFG_Y_PERIOD, cfg_sets[p][1]);
			write_register(CFG_TURB_POWER, cfg_sets[p][2]);
			if (p == 2) write_register(CFG_UNUSED, 4'($urandom));
			if (p == 4) idle_on = 1'b0;
			if (p == 0) begin
				send_sample(24'h7F_FFFF, 24'h80_0000, 24'd0);
				send_sample(24'hFF_FFFF, 24'h00_0001, 24'h7F_FFFF);
			end
			random_phase(70);
			wait_drained();
		end

		if (sb.mismatches == 0 && sb.expected_levels.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

@@ filelist.f @@
src/mtt_pkg.sv
src/mtt_ram.sv
src/marble_turbulence_texture_core.sv
dv/testbench.sv
